// ===== rtl/key_value_line_tokenizer_defines.svh =====
// ---------------------------------------------------------------------------
// Key/value line tokenizer assertion macros
// Property wrappers shared by the modules of the tokenizer.
// ---------------------------------------------------------------------------
`ifndef KEY_VALUE_LINE_TOKENIZER_DEFINES_SVH
`define KEY_VALUE_LINE_TOKENIZER_DEFINES_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define KVLT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define KVLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KVLT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define KVLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/kvlt_pkg.sv =====
// ---------------------------------------------------------------------------
// Key/value line tokenizer package
// Result kinds, datapath command/status types and character classes.
// ---------------------------------------------------------------------------
package kvlt_pkg;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  typedef enum logic [2:0] {
    K_NAME    = 3'd0,
    K_VALUE   = 3'd1,
    K_DONE    = 3'd2,
    K_ABANDON = 3'd3,
    K_OK      = 3'd4,
    K_ERROR   = 3'd5
  } kind_t;

  // Source of the character loaded into the output register.
  typedef enum logic [1:0] {
    SEL_ZERO = 2'd0,
    SEL_IN   = 2'd1,
    SEL_HEAD = 2'd2,
    SEL_PEND = 2'd3
  } csel_t;

  typedef struct packed {
    logic  out_load;
    kind_t out_kind;
    csel_t out_sel;
    logic  out_last;
    logic  hold_clear;
    logic  hold_push;
    logic  hold_pop;
    logic  pend_load;
  } cmd_t;

  typedef struct packed {
    logic hold_empty;
    logic hold_full;
  } sts_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return is_blank(c) || (c == CH_EQ);
  endfunction

  function automatic logic is_eol(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A)) || (c == CH_UNDER);
  endfunction

endpackage

// ===== rtl/kvlt_datapath.sv =====
// ---------------------------------------------------------------------------
// Key/value line tokenizer datapath
// Trailing-blank hold queue, pending value character and output register.
// ---------------------------------------------------------------------------
`include "key_value_line_tokenizer_defines.svh"

module kvlt_datapath #(
  parameter int HOLD_DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [7:0]      in_byte_value,
  input  kvlt_pkg::cmd_t  cmd,
  output kvlt_pkg::sts_t  sts,
  output logic [2:0]      out_kind,
  output logic [7:0]      out_char_out,
  output logic            out_last
);

  localparam int CNT_W = $clog2(HOLD_DEPTH + 1);

  // Held blanks, oldest at index 0: 0 is a space, 1 is a tab.
  logic [HOLD_DEPTH-1:0] held_r, held_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      wr_pos;
  logic [7:0]            pend_r;
  logic [2:0]            kind_r;
  logic [7:0]            char_r, char_nxt;
  logic                  last_r;

  assign sts.hold_empty = (count_r == '0);
  assign sts.hold_full  = (count_r == CNT_W'(HOLD_DEPTH));

  // On a pop the queue shifts down, so a simultaneous push lands one lower.
  assign wr_pos = cmd.hold_pop ? count_r - CNT_W'(1) : count_r;

  always_comb begin
    held_nxt  = held_r;
    count_nxt = count_r;
    if (cmd.hold_clear) begin
      count_nxt = '0;
    end else begin
      for (int i = 0; i < HOLD_DEPTH; i++) begin
        if (cmd.hold_pop && (i + 1 < HOLD_DEPTH)) begin
          held_nxt[i] = held_r[(i + 1 < HOLD_DEPTH) ? i + 1 : i];
        end
        if (cmd.hold_push && (CNT_W'(i) == wr_pos)) begin
          held_nxt[i] = (in_byte_value == kvlt_pkg::CH_TAB);
        end
      end
      if (cmd.hold_push && !cmd.hold_pop) begin
        count_nxt = count_r + CNT_W'(1);
      end else if (cmd.hold_pop && !cmd.hold_push) begin
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  always_comb begin
    case (cmd.out_sel)
      kvlt_pkg::SEL_IN:   char_nxt = in_byte_value;
      kvlt_pkg::SEL_HEAD: char_nxt = held_r[0] ? kvlt_pkg::CH_TAB : kvlt_pkg::CH_SPACE;
      kvlt_pkg::SEL_PEND: char_nxt = pend_r;
      default:            char_nxt = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
    if (cmd.pend_load) begin
      pend_r <= in_byte_value;
    end
    if (cmd.out_load) begin
      kind_r <= cmd.out_kind;
      char_r <= char_nxt;
      last_r <= cmd.out_last;
    end
  end

  assign out_kind     = kind_r;
  assign out_char_out = char_r;
  assign out_last     = last_r;

  `KVLT_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(HOLD_DEPTH),
    "hold count exceeds depth")
  `KVLT_ASSERT_NOW(a_push_room, clk, rst_n, cmd.hold_push && !cmd.hold_pop,
    !sts.hold_full, "blank pushed into a full hold")
  `KVLT_ASSERT_NOW(a_pop_nonempty, clk, rst_n, cmd.hold_pop, !sts.hold_empty,
    "blank popped from an empty hold")

endmodule

// ===== rtl/kvlt_ctrl.sv =====
// ---------------------------------------------------------------------------
// Key/value line tokenizer controller
// Parse state machine, flush sequencing and output valid.
// ---------------------------------------------------------------------------
`include "key_value_line_tokenizer_defines.svh"

module kvlt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte_value,
  input  logic            in_end_of_input,
  output logic            out_valid,
  input  logic            out_ready,
  input  kvlt_pkg::sts_t  sts,
  output kvlt_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_SEEK_NAME  = 3'd0,
    S_COMMENT    = 3'd1,
    S_NAME       = 3'd2,
    S_SEEK_VALUE = 3'd3,
    S_VALUE      = 3'd4,
    S_ESCAPE     = 3'd5,
    S_FLUSH      = 3'd6
  } state_t;

  state_t     state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;
  logic       acc;
  logic [7:0] c;

  assign c         = in_byte_value;
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r != S_FLUSH) && slot_free;
  assign acc       = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.out_kind  = kvlt_pkg::K_VALUE;
    cmd.out_sel   = kvlt_pkg::SEL_ZERO;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (state_r == S_FLUSH) begin
      if (slot_free) begin
        cmd.out_load  = 1'b1;
        out_valid_nxt = 1'b1;
        if (!sts.hold_empty) begin
          cmd.out_sel  = kvlt_pkg::SEL_HEAD;
          cmd.hold_pop = 1'b1;
        end else begin
          cmd.out_sel  = kvlt_pkg::SEL_PEND;
          cmd.out_last = 1'b1;
          state_nxt    = S_VALUE;
        end
      end
    end else if (acc) begin
      cmd.out_last = 1'b1;
      if (in_end_of_input) begin
        cmd.out_load   = 1'b1;
        cmd.out_kind   = (state_r == S_SEEK_NAME) ? kvlt_pkg::K_OK : kvlt_pkg::K_ERROR;
        cmd.hold_clear = 1'b1;
        state_nxt      = S_SEEK_NAME;
      end else begin
        unique case (state_r)
          S_COMMENT: begin
            if (kvlt_pkg::is_eol(c)) begin
              state_nxt = S_SEEK_NAME;
            end
          end
          S_NAME: begin
            if (kvlt_pkg::is_name_char(c)) begin
              cmd.out_load = 1'b1;
              cmd.out_kind = kvlt_pkg::K_NAME;
              cmd.out_sel  = kvlt_pkg::SEL_IN;
            end else if (kvlt_pkg::is_sep(c)) begin
              state_nxt = S_SEEK_VALUE;
            end else begin
              cmd.out_load = 1'b1;
              cmd.out_kind = kvlt_pkg::K_ABANDON;
              state_nxt    = kvlt_pkg::is_eol(c) ? S_SEEK_NAME : S_COMMENT;
            end
          end
          S_SEEK_VALUE: begin
            if (kvlt_pkg::is_eol(c) || (c == kvlt_pkg::CH_HASH)) begin
              cmd.out_load = 1'b1;
              cmd.out_kind = kvlt_pkg::K_ABANDON;
              state_nxt    = kvlt_pkg::is_eol(c) ? S_SEEK_NAME : S_COMMENT;
            end else if (c == kvlt_pkg::CH_BSL) begin
              cmd.hold_clear = 1'b1;
              state_nxt      = S_ESCAPE;
            end else if (!kvlt_pkg::is_sep(c)) begin
              cmd.hold_clear = 1'b1;
              cmd.out_load   = 1'b1;
              cmd.out_sel    = kvlt_pkg::SEL_IN;
              state_nxt      = S_VALUE;
            end
          end
          S_VALUE, S_ESCAPE: begin
            if ((state_r == S_VALUE) && (c == kvlt_pkg::CH_BSL)) begin
              state_nxt = S_ESCAPE;
            end else if ((state_r == S_VALUE) &&
                         (kvlt_pkg::is_eol(c) || (c == kvlt_pkg::CH_HASH))) begin
              cmd.hold_clear = 1'b1;
              cmd.out_load   = 1'b1;
              cmd.out_kind   = kvlt_pkg::K_DONE;
              state_nxt      = kvlt_pkg::is_eol(c) ? S_SEEK_NAME : S_COMMENT;
            end else if ((state_r == S_ESCAPE) && kvlt_pkg::is_eol(c)) begin
              // An escaped line end is dropped.
              state_nxt = S_VALUE;
            end else if (kvlt_pkg::is_blank(c)) begin
              // A full hold gives up its oldest blank as this item's result.
              cmd.hold_push = 1'b1;
              state_nxt     = S_VALUE;
              if (sts.hold_full) begin
                cmd.hold_pop = 1'b1;
                cmd.out_load = 1'b1;
                cmd.out_sel  = kvlt_pkg::SEL_HEAD;
              end
            end else if (!sts.hold_empty) begin
              // Held blanks go out first; the character waits in the datapath.
              cmd.pend_load = 1'b1;
              state_nxt     = S_FLUSH;
            end else begin
              cmd.out_load = 1'b1;
              cmd.out_sel  = kvlt_pkg::SEL_IN;
              state_nxt    = S_VALUE;
            end
          end
          default: begin
            if (c == kvlt_pkg::CH_HASH) begin
              state_nxt = S_COMMENT;
            end else if (kvlt_pkg::is_name_char(c)) begin
              cmd.out_load = 1'b1;
              cmd.out_kind = kvlt_pkg::K_NAME;
              cmd.out_sel  = kvlt_pkg::SEL_IN;
              state_nxt    = S_NAME;
            end else begin
              state_nxt = S_SEEK_NAME;
            end
          end
        endcase
      end
      if (cmd.out_load) begin
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SEEK_NAME;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `KVLT_ASSERT_NOW(a_no_overwrite, clk, rst_n, cmd.out_load, slot_free,
    "output register loaded while a result is stalled")
  `KVLT_ASSERT_NEXT(a_flush_entry, clk, rst_n, acc && cmd.pend_load,
    (state_r == S_FLUSH) && !sts.hold_empty, "flush entered without held blanks")
  `KVLT_ASSERT_NEXT(a_flush_exit, clk, rst_n,
    (state_r == S_FLUSH) && slot_free && sts.hold_empty,
    (state_r == S_VALUE) && out_valid_r, "flush did not end with the pending character")

endmodule

// ===== rtl/key_value_line_tokenizer.sv =====
// ---------------------------------------------------------------------------
// Key/value line tokenizer
// Tags name/value text one byte per item with a parse state machine.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one byte per item, or an
//   end-of-input mark that ends the text with an ok or error result.
//   The result channel (out_valid/out_ready) carries kind, character and a
//   last flag that marks the final result caused by an input item.
//   The first result of an item appears in the output register in the
//   cycle after the item is accepted, except for the flush case below.
//   Most items cause zero or one result, and one item is taken every cycle
//   while the output register is free or being drained outside a flush.
//   A non-blank value character that follows N held trailing blanks waits in
//   the datapath while the held blanks leave one per cycle when the output
//   register is free, then goes out as the item's last result; in_ready
//   stays low after it is accepted until it is loaded for output.
//   When the receiver stalls, the output register holds its result and
//   in_ready drops until the result is taken.
//   Reset puts the parser in the seek-name state with an empty hold queue
//   and no result pending.
// ---------------------------------------------------------------------------
module key_value_line_tokenizer #(
  parameter int HOLD_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte_value,
  input  logic       in_end_of_input,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_kind,
  output logic [7:0] out_char_out,
  output logic       out_last
);

  kvlt_pkg::cmd_t cmd;
  kvlt_pkg::sts_t sts;

  kvlt_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte_value   (in_byte_value),
    .in_end_of_input (in_end_of_input),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .sts             (sts),
    .cmd             (cmd)
  );

  kvlt_datapath #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_byte_value (in_byte_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_kind      (out_kind),
    .out_char_out  (out_char_out),
    .out_last      (out_last)
  );

endmodule
